### hdl/sti_pkg.sv
// ----------------------------------------------------------------------------
// sti_pkg
// Shared types and constants of the calibration table interpolator.
// ----------------------------------------------------------------------------
package sti_pkg;

  // table geometry
  localparam int TableDepth = 64;
  localparam int IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CntW       = IdxW + 1;

  // field widths
  localparam int SampleW = 16;
  localparam int TempW   = 21;
  localparam int StepW   = 8;
  localparam int DegW    = 10;

  // running base temperature min + step*i, signed
  localparam int AccW     = IdxW + StepW + 2;
  localparam int OutCalcW = (AccW + 4 > TempW) ? AccW + 4 : TempW;

  // shared divider: step*a*16 over b
  localparam int NumW = StepW + SampleW + 4;
  localparam int DenW = SampleW;

  // configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 10;

  localparam logic [CfgIdxW-1:0] CfgMinTemp  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxTemp  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgStep     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgEntries  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgNegCoeff = 3'd4;

  // item modes
  localparam logic ModeConvert = 1'b0;
  localparam logic ModeWrite   = 1'b1;

  // range status codes
  localparam logic [1:0] StatusInterp = 2'd0;
  localparam logic [1:0] StatusMin    = 2'd1;
  localparam logic [1:0] StatusMax    = 2'd2;

  typedef struct packed {
    logic               mode;
    logic [5:0]         entry_index;
    logic [SampleW-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic signed [TempW-1:0] temperature_q4;
    logic [1:0]              range_status;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CMP,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT
  } state_e;

endpackage

### hdl/sti_table.sv
// ----------------------------------------------------------------------------
// sti_table
// Calibration table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sti_table (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [sti_pkg::IdxW-1:0]    wr_addr_i,
  input  logic [sti_pkg::SampleW-1:0] wr_data_i,
  input  logic [sti_pkg::IdxW-1:0]    rd_addr_i,
  output logic [sti_pkg::SampleW-1:0] rd_data_o
);

  logic [sti_pkg::SampleW-1:0] mem_q [sti_pkg::TableDepth];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

### hdl/sti_divider.sv
// ----------------------------------------------------------------------------
// sti_divider
// Restoring divider, one quotient bit per cycle through a shared subtractor.
// ----------------------------------------------------------------------------
module sti_divider (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [sti_pkg::NumW-1:0] num_i,
  input  logic [sti_pkg::DenW-1:0] den_i,
  output logic                     done_o,
  output logic [sti_pkg::NumW-1:0] quot_o
);

  localparam int BitCntW = $clog2(sti_pkg::NumW + 1);

  logic [sti_pkg::DenW-1:0] rem_q, rem_d;
  logic [sti_pkg::NumW-1:0] quo_q, quo_d;
  logic [sti_pkg::DenW-1:0] den_q, den_d;
  logic [BitCntW-1:0]       bits_q, bits_d;
  logic                     run_q, run_d;
  logic                     done_q, done_d;
  logic [sti_pkg::DenW:0]   shifted;
  logic [sti_pkg::DenW:0]   trial;

  // one shift and trial subtract per cycle
  always_comb begin
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    bits_d  = bits_q;
    run_d   = run_q;
    done_d  = 1'b0;
    shifted = {rem_q, quo_q[sti_pkg::NumW-1]};
    trial   = shifted - {1'b0, den_q};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
      bits_d = BitCntW'(sti_pkg::NumW);
      run_d  = 1'b1;
    end else if (run_q) begin
      if (!trial[sti_pkg::DenW]) begin
        rem_d = trial[sti_pkg::DenW-1:0];
        quo_d = {quo_q[sti_pkg::NumW-2:0], 1'b1};
      end else begin
        rem_d = shifted[sti_pkg::DenW-1:0];
        quo_d = {quo_q[sti_pkg::NumW-2:0], 1'b0};
      end
      bits_d = bits_q - 1'b1;
      if (bits_q == BitCntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      bits_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      bits_q <= bits_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

### hdl/sensor_table_interpolator.sv
// ----------------------------------------------------------------------------
// sensor_table_interpolator
// Converts a raw reading to temperature by walking the calibration table
// and interpolating between neighboring entries.
// ----------------------------------------------------------------------------
// A table write item is taken while idle. A conversion with a non-empty table
// scans it with a memory read state and a compare state for each entry, then,
// when it interpolates, a multiply state and, over a positive span, a divider
// start state and the divider wait state. The done_o strobe is registered from
// the final state, lasts one cycle and the receiver cannot stall it.
// Reset sets min 0, max 0, step 5, entries 1, coefficient 0; table undefined.
// ----------------------------------------------------------------------------
module sensor_table_interpolator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  sti_pkg::in_item_t            in_item_i,
  output logic                         done_o,
  output sti_pkg::result_t             result_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sti_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sti_pkg::CfgDataW-1:0] cfg_data_i
);

  // configuration registers
  logic signed [sti_pkg::DegW-1:0] min_temp_q;
  logic signed [sti_pkg::DegW-1:0] max_temp_q;
  logic [sti_pkg::StepW-1:0]       step_q;
  logic [6:0]                      entries_q;
  logic                            neg_coeff_q;

  // sequencer state
  sti_pkg::state_e                 state_q, state_d;
  logic [sti_pkg::CntW-1:0]        cnt_q, cnt_d;
  logic [sti_pkg::CntW-1:0]        count_q, count_d;
  logic [sti_pkg::SampleW-1:0]     reading_q, reading_d;
  logic [sti_pkg::SampleW-1:0]     prev_q, prev_d;
  logic signed [sti_pkg::AccW-1:0] acc_q, acc_d;
  logic [sti_pkg::SampleW-1:0]     a_q, a_d;
  logic [sti_pkg::SampleW-1:0]     b_q, b_d;
  logic                            bpos_q, bpos_d;
  logic [sti_pkg::NumW-1:0]        prod_q, prod_d;
  sti_pkg::result_t                res_q, res_d;
  logic                            done_q, done_d;

  // datapath helpers
  logic                                accept;
  logic                                tbl_wr;
  logic [sti_pkg::SampleW-1:0]         cur;
  logic                                hit;
  logic [sti_pkg::SampleW:0]           b_diff;
  logic [sti_pkg::StepW+sti_pkg::SampleW-1:0] mul;
  logic signed [sti_pkg::OutCalcW-1:0] acc_ext;
  logic signed [sti_pkg::OutCalcW-1:0] base_q4;
  logic signed [sti_pkg::TempW-1:0]    min_q4;
  logic signed [sti_pkg::TempW-1:0]    max_q4;
  logic [sti_pkg::TempW-1:0]           interp_c0;
  logic                                div_start;
  logic                                div_done;
  logic [sti_pkg::NumW-1:0]            div_quot;

  assign accept      = start && !busy;
  assign tbl_wr      = accept && (in_item_i.mode == sti_pkg::ModeWrite) &&
                       (32'(in_item_i.entry_index) < sti_pkg::TableDepth);
  assign cfg_ready_o = 1'b1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_temp_q  <= '0;
      max_temp_q  <= '0;
      step_q      <= sti_pkg::StepW'(5);
      entries_q   <= 7'd1;
      neg_coeff_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        sti_pkg::CfgMinTemp:  min_temp_q  <= cfg_data_i;
        sti_pkg::CfgMaxTemp:  max_temp_q  <= cfg_data_i;
        sti_pkg::CfgStep:     step_q      <= cfg_data_i[sti_pkg::StepW-1:0];
        sti_pkg::CfgEntries:  entries_q   <= cfg_data_i[6:0];
        sti_pkg::CfgNegCoeff: neg_coeff_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  sti_table u_table (
    .clk_i     (clk_i),
    .wr_en_i   (tbl_wr),
    .wr_addr_i (sti_pkg::IdxW'(in_item_i.entry_index)),
    .wr_data_i (in_item_i.sample_value),
    .rd_addr_i (cnt_q[sti_pkg::IdxW-1:0]),
    .rd_data_o (cur)
  );

  sti_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod_q),
    .den_i   (b_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // compare, spans, product and fixed point scaling
  assign hit    = neg_coeff_q ? (cur >= reading_q) : (cur <= reading_q);
  assign b_diff = neg_coeff_q ? ({1'b0, cur} - {1'b0, prev_q})
                              : ({1'b0, prev_q} - {1'b0, cur});
  assign mul     = (sti_pkg::StepW + sti_pkg::SampleW)'(step_q) *
                   (sti_pkg::StepW + sti_pkg::SampleW)'(a_q);
  assign acc_ext = sti_pkg::OutCalcW'(acc_q);
  assign base_q4 = acc_ext <<< 4;
  assign min_q4  = sti_pkg::TempW'(min_temp_q) <<< 4;
  assign max_q4  = sti_pkg::TempW'(max_temp_q) <<< 4;
  assign interp_c0 = base_q4[sti_pkg::TempW-1:0];
  assign div_start = (state_q == sti_pkg::ST_DIV_GO);

  // sequencer
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    count_d   = count_q;
    reading_d = reading_q;
    prev_d    = prev_q;
    acc_d     = acc_q;
    a_d       = a_q;
    b_d       = b_q;
    bpos_d    = bpos_q;
    prod_d    = prod_q;
    res_d     = res_q;
    done_d    = 1'b0;
    case (state_q)
      sti_pkg::ST_IDLE: begin
        if (accept && (in_item_i.mode == sti_pkg::ModeConvert)) begin
          reading_d = in_item_i.sample_value;
          cnt_d     = '0;
          prev_d    = '0;
          acc_d     = sti_pkg::AccW'(min_temp_q);
          if (32'(entries_q) > sti_pkg::TableDepth) begin
            count_d = sti_pkg::CntW'(sti_pkg::TableDepth);
          end else begin
            count_d = sti_pkg::CntW'(entries_q);
          end
          if (entries_q == '0) begin
            // empty table gives the maximum
            res_d.temperature_q4 = max_q4;
            res_d.range_status   = sti_pkg::StatusMax;
            done_d               = 1'b1;
          end else begin
            state_d = sti_pkg::ST_FETCH;
          end
        end
      end
      sti_pkg::ST_FETCH: begin
        state_d = sti_pkg::ST_CMP;
      end
      sti_pkg::ST_CMP: begin
        if (hit) begin
          if (cnt_q == '0) begin
            // reading at or before the first entry
            res_d.temperature_q4 = min_q4;
            res_d.range_status   = sti_pkg::StatusMin;
            done_d               = 1'b1;
            state_d              = sti_pkg::ST_IDLE;
          end else begin
            a_d     = neg_coeff_q ? (cur - reading_q) : (reading_q - cur);
            b_d     = b_diff[sti_pkg::SampleW-1:0];
            bpos_d  = !b_diff[sti_pkg::SampleW] && (b_diff != '0);
            state_d = sti_pkg::ST_MUL;
          end
        end else begin
          prev_d = cur;
          acc_d  = acc_q + $signed({{(sti_pkg::AccW-sti_pkg::StepW){1'b0}}, step_q});
          cnt_d  = cnt_q + 1'b1;
          if (cnt_q + 1'b1 == count_q) begin
            // walked off the end of the table
            res_d.temperature_q4 = max_q4;
            res_d.range_status   = sti_pkg::StatusMax;
            done_d               = 1'b1;
            state_d              = sti_pkg::ST_IDLE;
          end else begin
            state_d = sti_pkg::ST_FETCH;
          end
        end
      end
      sti_pkg::ST_MUL: begin
        prod_d = {mul, 4'b0000};
        if (bpos_q) begin
          state_d = sti_pkg::ST_DIV_GO;
        end else begin
          // no span, no correction term
          res_d.temperature_q4 = interp_c0;
          res_d.range_status   = sti_pkg::StatusInterp;
          done_d               = 1'b1;
          state_d              = sti_pkg::ST_IDLE;
        end
      end
      sti_pkg::ST_DIV_GO: begin
        state_d = sti_pkg::ST_DIV_WAIT;
      end
      sti_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          res_d.temperature_q4 = interp_c0 - div_quot[sti_pkg::TempW-1:0];
          res_d.range_status   = sti_pkg::StatusInterp;
          done_d               = 1'b1;
          state_d              = sti_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sti_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sti_pkg::ST_IDLE;
      cnt_q   <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    reading_q <= reading_d;
    prev_q    <= prev_d;
    acc_q     <= acc_d;
    a_q       <= a_d;
    b_q       <= b_d;
    bpos_q    <= bpos_d;
    prod_q    <= prod_d;
    res_q     <= res_d;
  end

  assign busy     = (state_q != sti_pkg::ST_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the calibration table interpolator. Items go in
// on the start/busy handshake, and every conversion is predicted at
// acceptance from a local copy of the table and the settings. Each result
// strobe is compared with the oldest prediction. The run loads ascending
// and descending curves under several settings, then random curves with
// random readings and stray table writes.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sti_pkg::*;

  localparam int SettleCycles  = 200;
  localparam int WatchdogLimit = 4000;
  localparam int MaxPrinted    = 40;

  // predicts conversions and checks result strobes in order
  class temperature_checker;
    int                 min_deg;
    int                 max_deg;
    int                 step_deg;
    int                 entry_count;
    bit                 ascending;
    logic [SampleW-1:0] cal_points [TableDepth];
    result_t            pending_temps [$];
    int                 mismatches;
    int                 conversions_checked;

    function new();
      min_deg     = 0;
      max_deg     = 0;
      step_deg    = 5;
      entry_count = 1;
      ascending   = 1'b0;
      foreach (cal_points[k]) cal_points[k] = '0;
    endfunction

    function void set_register(logic [CfgIdxW-1:0] sel, logic [CfgDataW-1:0] data);
      case (sel)
        CfgMinTemp:  min_deg = int'($signed(data[DegW-1:0]));
        CfgMaxTemp:  max_deg = int'($signed(data[DegW-1:0]));
        CfgStep:     step_deg = int'(data[StepW-1:0]);
        CfgEntries:  entry_count = int'(data[CntW-1:0]);
        CfgNegCoeff: ascending = data[0];
        default: ;
      endcase
    endfunction

    // walk the table to the first qualifying entry, then clamp or interpolate
    function result_t predict_temperature(logic [SampleW-1:0] reading);
      int      rd, last, k, here, prev, a, b;
      longint  corr, base;
      bit      hit;
      result_t r;
      rd = int'(reading);
      last = (entry_count > TableDepth) ? TableDepth : entry_count;
      r.temperature_q4 = TempW'(max_deg * 16);
      r.range_status   = StatusMax;
      hit  = 1'b0;
      prev = 0;
      for (k = 0; k < last && !hit; k++) begin
        here = int'(cal_points[k]);
        if (ascending ? (here >= rd) : (here <= rd)) begin
          hit = 1'b1;
          if (k == 0) begin
            r.temperature_q4 = TempW'(min_deg * 16);
            r.range_status   = StatusMin;
          end else begin
            a = ascending ? here - rd : rd - here;
            b = ascending ? here - prev : prev - here;
            // no correction over a flat or reversed span
            corr = (b > 0 && a >= 0) ? (longint'(step_deg) * a * 16) / b : 0;
            base = (longint'(min_deg) + longint'(step_deg) * k) * 16;
            r.temperature_q4 = TempW'(base - corr);
            r.range_status   = StatusInterp;
          end
        end
        prev = here;
      end
      return r;
    endfunction

    function void note_item(in_item_t it);
      if (it.mode == ModeWrite) begin
        cal_points[it.entry_index] = it.sample_value;
      end else begin
        pending_temps.push_back(predict_temperature(it.sample_value));
      end
    endfunction

    // print past the cap is suppressed to keep the log short
    task report(string what);
      mismatches++;
      if (mismatches <= MaxPrinted) $display("mismatch: %s", what);
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending_temps.size() == 0) begin
        report($sformatf("result %0d / status %0d with no conversion pending",
                         $signed(got.temperature_q4), got.range_status));
      end else begin
        want = pending_temps.pop_front();
        conversions_checked++;
        if (got.temperature_q4 !== want.temperature_q4)
          report($sformatf("conversion %0d: temperature_q4 %0d, want %0d",
                           conversions_checked, $signed(got.temperature_q4),
                           $signed(want.temperature_q4)));
        if (got.range_status !== want.range_status)
          report($sformatf("conversion %0d: range_status %0d, want %0d",
                           conversions_checked, got.range_status, want.range_status));
      end
    endtask
  endclass

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                start     = 1'b0;
  logic                busy;
  in_item_t            item      = '0;
  logic                done;
  result_t             result;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  temperature_checker sb = new();
  bit idle_enable = 1'b1;
  int items_sent;
  int writes_sent;
  int settings_applied;
  int stall_cycles;

  sensor_table_interpolator DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item_i  (item),
    .done_o     (done),
    .result_o   (result),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // result strobes cannot be held off, check each one at its edge
  always @(posedge clk) begin
    if (rst_n && done) sb.check_result(result);
  end

  // watchdog on cycles with no handshake of any kind
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $display("watchdog: no handshake for %0d cycles", stall_cycles);
      $display("FAILED: results differ");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // hand one item over on start/busy, start stays high for a following item
  task automatic send_item(logic mode, int unsigned idx, int unsigned value);
    in_item_t it;
    it.mode         = mode;
    it.entry_index  = idx[5:0];
    it.sample_value = value[SampleW-1:0];
    while (idle_enable && $urandom_range(0, 99) < 34) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(it);
    items_sent++;
    if (mode == ModeWrite) writes_sent++;
  endtask

  // write all five registers, block is idle
  task automatic apply_settings(int min_deg, int max_deg, int step_deg, int entries, bit asc);
    logic [CfgIdxW-1:0]  sel [5];
    logic [CfgDataW-1:0] value [5];
    int k;
    sel[0] = CfgMinTemp;   value[0] = CfgDataW'(min_deg);
    sel[1] = CfgMaxTemp;   value[1] = CfgDataW'(max_deg);
    sel[2] = CfgStep;      value[2] = CfgDataW'(step_deg);
    sel[3] = CfgEntries;   value[3] = CfgDataW'(entries);
    sel[4] = CfgNegCoeff;  value[4] = CfgDataW'(asc);
    for (k = 0; k < 5; k++) begin
      while (idle_enable && $urandom_range(0, 99) < 34) begin
        cfg_valid <= 1'b0;
        @(posedge clk);
      end
      cfg_valid <= 1'b1;
      cfg_index <= sel[k];
      cfg_data  <= value[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.set_register(sel[k], value[k]);
    end
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  // wait out all pending conversions, then the longest walk for a trailing write
  task automatic drain();
    start <= 1'b0;
    while (sb.pending_temps.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // load a random monotone curve, then convert readings mostly inside it
  task automatic run_curve_phase(int min_deg, int max_deg, int step_deg, int entries, bit asc,
                                 int conversions);
    logic [SampleW-1:0] curve [TableDepth];
    int n, k, lvl, roll;
    logic [SampleW-1:0] reading;
    apply_settings(min_deg, max_deg, step_deg, entries, asc);
    n = (entries > TableDepth) ? TableDepth : entries;
    // ascending list, repeats allowed; descending tables store it reversed
    lvl = $urandom_range(0, 4000);
    for (k = 0; k < n; k++) begin
      curve[k] = lvl[SampleW-1:0];
      lvl = lvl + $urandom_range(0, (65535 - lvl) / (n - k));
    end
    for (k = 0; k < n; k++) begin
      send_item(ModeWrite, asc ? k : n - 1 - k, curve[k]);
    end
    for (k = 0; k < conversions; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        // stray write anywhere in the table
        send_item(ModeWrite, $urandom_range(0, TableDepth - 1), $urandom_range(0, 65535));
      end else begin
        if (roll < 18 || n == 0) reading = $urandom_range(0, 65535);
        else if (roll < 30) reading = curve[$urandom_range(0, n - 1)];
        else reading = $urandom_range(curve[n-1], curve[0]);
        send_item(ModeConvert, $urandom_range(0, TableDepth - 1), reading);
      end
    end
    drain();
  endtask

  initial begin
    int p;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ascending table, extreme temperatures, exact hits and beyond the end
    apply_settings(-512, 511, 255, 4, 1'b1);
    send_item(ModeWrite, 0, 100);
    send_item(ModeWrite, 1, 1000);
    send_item(ModeWrite, 2, 30000);
    send_item(ModeWrite, 3, 65000);
    send_item(ModeConvert, 63, 0);
    send_item(ModeConvert, 0, 100);
    send_item(ModeConvert, 0, 500);
    send_item(ModeConvert, 0, 1000);
    send_item(ModeConvert, 0, 65000);
    send_item(ModeConvert, 0, 65535);
    drain();

    // descending table with zero step
    apply_settings(511, -512, 0, 4, 1'b0);
    send_item(ModeWrite, 0, 65535);
    send_item(ModeWrite, 1, 40000);
    send_item(ModeWrite, 2, 2000);
    send_item(ModeWrite, 3, 0);
    send_item(ModeConvert, 0, 65535);
    send_item(ModeConvert, 0, 50000);
    send_item(ModeConvert, 0, 0);
    drain();

    // reading past a short descending table
    apply_settings(0, 100, 1, 3, 1'b0);
    send_item(ModeConvert, 0, 1000);
    drain();

    // empty table
    apply_settings(-1, 7, 1, 0, 1'b1);
    send_item(ModeConvert, 0, 12345);
    drain();

    // random curves; full table first, then a count past the table depth
    for (p = 0; p < 10; p++) begin
      idle_enable = (p != 3);
      case (p)
        0: run_curve_phase(511, -512, 255, TableDepth, 1'b1, 30);
        1: run_curve_phase(-512, 511, 1, 127, 1'b0, 30);
        default: begin
          run_curve_phase(int'($urandom_range(0, 1023)) - 512,
                          int'($urandom_range(0, 1023)) - 512,
                          $urandom_range(1, 255),
                          ($urandom_range(0, 9) == 0) ? $urandom_range(17, TableDepth)
                                                      : $urandom_range(1, 16),
                          $urandom_range(0, 1), 32);
        end
      endcase
    end
    idle_enable = 1'b1;
    drain();

    $display("ran %0d items (%0d table writes) under %0d register settings",
             items_sent, writes_sent, settings_applied);
    $display("checked %0d conversions over ascending, descending and empty tables",
             sb.conversions_checked);
    if (sb.pending_temps.size() != 0)
      sb.report($sformatf("%0d conversions never produced a result", sb.pending_temps.size()));
    if (sb.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
